### src/c2pt_pkg.sv
`default_nettype none
// ============================================================================
// c2pt_pkg: shared types and arithmetic for the ten-moment converter
// Widths, the divider step, the kinetic index tables and saturation.
// ============================================================================
package c2pt_pkg;

    localparam int FRAC_BITS_DEF = 16;   // fraction bits of Q16.16
    localparam int WORD_BITS     = 32;   // saturation range
    localparam int FW            = 32;   // field width
    localparam int DW            = 31;   // density / floor width
    localparam int NW            = 63;   // numerator magnitude width
    localparam int QB            = 34;   // quotient bits kept (larger clamps)
    localparam int SW            = NW + 2;
    localparam int KW            = QB + 2;  // signed quotient
    localparam int PW            = KW + 1;  // pressure / energy sum
    localparam int NLANE         = 9;    // 3 velocities + 6 kinetic terms

    localparam int IA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int IB [6] = '{0, 1, 2, 1, 2, 2};

    localparam logic signed [PW-1:0] SAT_MAX =
        PW'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SAT_MIN = -SAT_MAX - PW'(1);

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [QB-1:0] q;
        logic [NW-1:0] rem;
    } lane_t;

    typedef struct packed {
        logic [DW-1:0]      d;
        logic [2:0][FW-1:0] mom;
        logic [5:0][FW-1:0] en;
    } side_t;

    typedef struct packed {
        logic          is_last;
        logic [FW-1:0] density;
        logic [FW-1:0] x;
        logic [FW-1:0] y;
        logic [FW-1:0] z;
        logic [FW-1:0] xx;
        logic [FW-1:0] yy;
        logic [FW-1:0] zz;
        logic [FW-1:0] xy;
        logic [FW-1:0] xz;
        logic [FW-1:0] yz;
    } res_t;

    // one restoring step: quotient bit b
    function automatic lane_t div_step(lane_t l, logic [DW-1:0] d, int b);
        logic [SW-1:0] dsh;
        logic [SW-1:0] rext;
        lane_t         r;
        dsh  = SW'(d) << b;
        rext = SW'(l.rem);
        r    = l;
        if (rext >= dsh)
        begin
            r.rem  = NW'(rext - dsh);
            r.q[b] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [FW-1:0] sat_word(logic signed [PW-1:0] v);
        logic [FW-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[FW-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[FW-1:0];
        else
            r = v[FW-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### src/conserved_to_primitive_tensor.sv
`default_nettype none
// ============================================================================
// conserved_to_primitive_tensor: ten-moment conserved to primitive converter
// Floors density, divides momenta and momentum products by density in a
// pipelined restoring divider, floors diagonal pressures, emits two results.
// ============================================================================
// Result one passes stage 1, stage 2, the divider chain, stage 4 and the output register,
//   result two (is_last) follows in the cycle right after it.
// The result port carries one item per cycle and each item yields two, so busy is
//   high for one cycle per accept and blocks the next item in that cycle.
// Reset: valid bits clear, both floor registers return to 1.
// The receiver cannot stall: done pulses for exactly one cycle per result.
module conserved_to_primitive_tensor
    import c2pt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_addr,
    input  wire logic [DW-1:0]        cfg_data,
    input  wire logic signed [FW-1:0] rho,
    input  wire logic signed [FW-1:0] mom_x,
    input  wire logic signed [FW-1:0] mom_y,
    input  wire logic signed [FW-1:0] mom_z,
    input  wire logic signed [FW-1:0] en_xx,
    input  wire logic signed [FW-1:0] en_yy,
    input  wire logic signed [FW-1:0] en_zz,
    input  wire logic signed [FW-1:0] en_xy,
    input  wire logic signed [FW-1:0] en_xz,
    input  wire logic signed [FW-1:0] en_yz,
    output logic                      done,
    output logic                      is_last,
    output logic signed [FW-1:0]      out_density,
    output logic signed [FW-1:0]      out_x,
    output logic signed [FW-1:0]      out_y,
    output logic signed [FW-1:0]      out_z,
    output logic signed [FW-1:0]      out_xx,
    output logic signed [FW-1:0]      out_yy,
    output logic signed [FW-1:0]      out_zz,
    output logic signed [FW-1:0]      out_xy,
    output logic signed [FW-1:0]      out_xz,
    output logic signed [FW-1:0]      out_yz
);

    localparam logic CFG_DENSITY  = 1'b0;
    localparam logic CFG_PRESSURE = 1'b1;

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [DW-1:0] dfloor_reg;
    logic [DW-1:0] pfloor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dfloor_reg <= DW'(1);
            pfloor_reg <= DW'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DENSITY:  dfloor_reg <= cfg_data;
                CFG_PRESSURE: pfloor_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input handshake: one item, then one blocked cycle so the
    // second result of every item has a slot on the result port.
    // ---------------------------------------------------------------
    logic busy_reg;
    logic accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= accept;
    end

    // ---------------------------------------------------------------
    // Stage 1: density floor, momentum magnitudes and signs
    // ---------------------------------------------------------------
    logic [DW-1:0] dfl;
    side_t         side_in;

    always_comb
    begin
        dfl = (dfloor_reg == '0) ? DW'(1) : dfloor_reg;
        side_in.d   = (rho > $signed({1'b0, dfl})) ? rho[DW-1:0] : dfl;
        side_in.mom = {mom_z, mom_y, mom_x};
        side_in.en  = {en_yz, en_xz, en_xy, en_zz, en_yy, en_xx};
    end

    logic          v1_reg;
    side_t         side1_reg;
    logic [FW-1:0] amag1_reg [3];
    logic          msgn1_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side_in;
        for (int k = 0; k < 3; k++)
        begin
            msgn1_reg[k] <= side_in.mom[k][FW-1];
            amag1_reg[k] <= side_in.mom[k][FW-1] ? (~side_in.mom[k] + FW'(1))
                                                 : side_in.mom[k];
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: numerators. Lanes 0..2 are velocities (mom << frac),
    // lanes 3..8 are momentum products for the kinetic tensor.
    // ---------------------------------------------------------------
    logic [NW-1:0]   num2_next [NLANE];
    logic            neg2_next [NLANE];
    logic [2*FW-1:0] prod      [6];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num2_next[k] = NW'(amag1_reg[k]) << FRAC_BITS;
            neg2_next[k] = msgn1_reg[k];
        end
        for (int i = 0; i < 6; i++)
        begin
            prod[i] = (2*FW)'(amag1_reg[IA[i]]) * (2*FW)'(amag1_reg[IB[i]]);
            num2_next[3+i] = prod[i][NW-1:0];
            neg2_next[3+i] = msgn1_reg[IA[i]] ^ msgn1_reg[IB[i]];
        end
    end

    logic          v2_reg;
    side_t         side2_reg;
    logic [NW-1:0] num2_reg [NLANE];
    logic          neg2_reg [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side1_reg;
        num2_reg  <= num2_next;
        neg2_reg  <= neg2_next;
    end

    // ---------------------------------------------------------------
    // Stage 3: overflow check (quotient would need more than QB bits,
    // which saturates anyway), then QB restoring steps, one per stage.
    // ---------------------------------------------------------------
    logic  vdv_reg   [QB+1];
    side_t sdv_reg   [QB+1];
    lane_t lane_reg  [QB+1][NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= QB; s++)
                vdv_reg[s] <= 1'b0;
        end
        else
        begin
            vdv_reg[0] <= v2_reg;
            for (int s = 0; s < QB; s++)
                vdv_reg[s+1] <= vdv_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        sdv_reg[0] <= side2_reg;
        for (int k = 0; k < NLANE; k++)
        begin
            lane_reg[0][k].neg <= neg2_reg[k];
            lane_reg[0][k].ovf <= (num2_reg[k] >> QB) >= NW'(side2_reg.d);
            lane_reg[0][k].q   <= '0;
            lane_reg[0][k].rem <= num2_reg[k];
        end
        for (int s = 0; s < QB; s++)
        begin
            sdv_reg[s+1] <= sdv_reg[s];
            for (int k = 0; k < NLANE; k++)
                lane_reg[s+1][k] <= div_step(lane_reg[s][k], sdv_reg[s].d, QB - 1 - s);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: signed quotients, clamped to +-2^QB on overflow
    // ---------------------------------------------------------------
    logic signed [KW-1:0] kin4_next [NLANE];
    logic [QB:0]          qmag      [NLANE];

    always_comb
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            qmag[k] = lane_reg[QB][k].ovf ? ((QB+1)'(1) << QB)
                                          : {1'b0, lane_reg[QB][k].q};
            kin4_next[k] = lane_reg[QB][k].neg ? -$signed({1'b0, qmag[k]})
                                               : $signed({1'b0, qmag[k]});
        end
    end

    logic                 v4_reg;
    side_t                side4_reg;
    logic signed [KW-1:0] kin4_reg [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= vdv_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        side4_reg <= sdv_reg[QB];
        kin4_reg  <= kin4_next;
    end

    // ---------------------------------------------------------------
    // Stage 5: pressures, diagonal floor, saturation, both results
    // ---------------------------------------------------------------
    logic signed [PW-1:0] pfl;
    logic signed [PW-1:0] ke   [6];
    logic signed [PW-1:0] prx  [6];
    logic signed [PW-1:0] prf  [3];
    logic signed [PW-1:0] enc  [3];
    logic                 flo  [3];
    logic [FW-1:0]        vel  [3];
    logic [FW-1:0]        prs  [6];
    logic [FW-1:0]        ens  [3];
    res_t                 res_a;
    res_t                 res_b;

    always_comb
    begin
        pfl = PW'($signed({1'b0, pfloor_reg}));
        for (int k = 0; k < 3; k++)
            vel[k] = sat_word(PW'(kin4_reg[k]));
        for (int i = 0; i < 6; i++)
        begin
            ke[i]  = PW'(kin4_reg[3+i]);
            prx[i] = PW'($signed(side4_reg.en[i])) - ke[i];
            prs[i] = sat_word(prx[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            // at or below the floor: pressure pinned, energy rebuilt
            flo[i] = (prx[i] <= pfl);
            prf[i] = flo[i] ? pfl : prx[i];
            enc[i] = flo[i] ? (pfl + ke[i]) : PW'($signed(side4_reg.en[i]));
            prs[i] = sat_word(prf[i]);
            ens[i] = sat_word(enc[i]);
        end

        res_a.is_last = 1'b0;
        res_a.density = FW'(side4_reg.d);
        res_a.x  = vel[0];
        res_a.y  = vel[1];
        res_a.z  = vel[2];
        res_a.xx = prs[0];
        res_a.yy = prs[1];
        res_a.zz = prs[2];
        res_a.xy = prs[3];
        res_a.xz = prs[4];
        res_a.yz = prs[5];

        res_b.is_last = 1'b1;
        res_b.density = FW'(side4_reg.d);
        res_b.x  = side4_reg.mom[0];
        res_b.y  = side4_reg.mom[1];
        res_b.z  = side4_reg.mom[2];
        res_b.xx = ens[0];
        res_b.yy = ens[1];
        res_b.zz = ens[2];
        res_b.xy = side4_reg.en[3];
        res_b.xz = side4_reg.en[4];
        res_b.yz = side4_reg.en[5];
    end

    // ---------------------------------------------------------------
    // Output: result one goes out, result two is held and follows in the next cycle.
    // Accepts are never back to back, so the two never collide.
    // ---------------------------------------------------------------
    logic done_reg;
    logic pend_reg;
    res_t out_reg;
    res_t hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v4_reg || pend_reg;
            pend_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            out_reg  <= res_a;
            hold_reg <= res_b;
        end
        else if (pend_reg)
            out_reg <= hold_reg;
    end

    assign done        = done_reg;
    assign is_last     = out_reg.is_last;
    assign out_density = out_reg.density;
    assign out_x       = out_reg.x;
    assign out_y       = out_reg.y;
    assign out_z       = out_reg.z;
    assign out_xx      = out_reg.xx;
    assign out_yy      = out_reg.yy;
    assign out_zz      = out_reg.zz;
    assign out_xy      = out_reg.xy;
    assign out_xz      = out_reg.xz;
    assign out_yz      = out_reg.yz;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |=> (done && !is_last))
        else $error("result one missing");

    a_second_result: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> (done && is_last))
        else $error("result two missing");

    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(v4_reg && pend_reg))
        else $error("items too close at output");

    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> !v1_reg)
        else $error("items entered back to back");

endmodule
`default_nettype wire

### sim/c2pt_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// c2pt_checker: result predictor and comparator for the ten-moment converter
// Tracks floor register writes, predicts both results of every accepted item
// and compares each strobed result against the oldest prediction.
// ============================================================================
module c2pt_checker
    import c2pt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_addr,
    input  wire logic [DW-1:0]        cfg_data,
    input  wire logic signed [FW-1:0] rho,
    input  wire logic signed [FW-1:0] mom_x,
    input  wire logic signed [FW-1:0] mom_y,
    input  wire logic signed [FW-1:0] mom_z,
    input  wire logic signed [FW-1:0] en_xx,
    input  wire logic signed [FW-1:0] en_yy,
    input  wire logic signed [FW-1:0] en_zz,
    input  wire logic signed [FW-1:0] en_xy,
    input  wire logic signed [FW-1:0] en_xz,
    input  wire logic signed [FW-1:0] en_yz,
    input  wire logic                 done,
    input  wire logic                 is_last,
    input  wire logic signed [FW-1:0] out_density,
    input  wire logic signed [FW-1:0] out_x,
    input  wire logic signed [FW-1:0] out_y,
    input  wire logic signed [FW-1:0] out_z,
    input  wire logic signed [FW-1:0] out_xx,
    input  wire logic signed [FW-1:0] out_yy,
    input  wire logic signed [FW-1:0] out_zz,
    input  wire logic signed [FW-1:0] out_xy,
    input  wire logic signed [FW-1:0] out_xz,
    input  wire logic signed [FW-1:0] out_yz,
    output int                        fail_count,
    output int                        pending
);

    localparam logic CFG_DENSITY_FLOOR  = 1'b0;
    localparam logic CFG_PRESSURE_FLOOR = 1'b1;

    logic [DW-1:0] rho_min;
    logic [DW-1:0] p_min;
    res_t          cell_q[$];

    function automatic logic [FW-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[FW-1:0];
    endfunction

    task automatic predict_cell(input logic signed [FW-1:0] c [10]);
        longint dmin;
        longint pmin;
        longint dens;
        longint m [3];
        longint e [6];
        longint ke;
        longint pr [6];
        longint ec [3];
        res_t   prim;
        res_t   cons;
        logic [FW-1:0] pv [6];
        logic [FW-1:0] vv [3];
        dmin = rho_min;
        if (dmin < 1)
            dmin = 1;
        pmin = p_min;
        dens = (longint'(c[0]) > dmin) ? longint'(c[0]) : dmin;
        for (int i = 0; i < 3; i++)
        begin
            m[i]  = c[1 + i];
            vv[i] = clamp32((m[i] * 65536) / dens);
        end
        for (int i = 0; i < 6; i++)
        begin
            e[i]  = c[4 + i];
            ke    = (m[IA[i]] * m[IB[i]]) / dens;
            pr[i] = e[i] - ke;
            if (i < 3)
            begin
                ec[i] = e[i];
                if (pr[i] <= pmin)
                begin
                    ec[i] = pmin + ke;
                    pr[i] = pmin;
                end
            end
            pv[i] = clamp32(pr[i]);
        end
        prim = '{1'b0, dens[FW-1:0], vv[0], vv[1], vv[2],
                 pv[0], pv[1], pv[2], pv[3], pv[4], pv[5]};
        cons = '{1'b1, dens[FW-1:0], c[1], c[2], c[3],
                 clamp32(ec[0]), clamp32(ec[1]), clamp32(ec[2]), c[7], c[8], c[9]};
        cell_q.push_back(prim);
        cell_q.push_back(cons);
    endtask

    task automatic cmp(input string f, input logic [FW-1:0] exp_v, input logic [FW-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", f, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [FW-1:0] c [10];
        res_t w;
        if (!rst_n)
        begin
            rho_min = 1;
            p_min   = 1;
        end
        else
        begin
            if (done)
            begin
                if (cell_q.size() == 0)
                begin
                    $error("unexpected result, is_last=%b", is_last);
                    fail_count++;
                end
                else
                begin
                    w = cell_q.pop_front();
                    cmp("is_last", FW'(w.is_last), FW'(is_last));
                    cmp("out_density", w.density, out_density);
                    cmp("out_x", w.x, out_x);
                    cmp("out_y", w.y, out_y);
                    cmp("out_z", w.z, out_z);
                    cmp("out_xx", w.xx, out_xx);
                    cmp("out_yy", w.yy, out_yy);
                    cmp("out_zz", w.zz, out_zz);
                    cmp("out_xy", w.xy, out_xy);
                    cmp("out_xz", w.xz, out_xz);
                    cmp("out_yz", w.yz, out_yz);
                end
            end
            // floors sampled before this edge's write takes effect
            if (start && !busy)
            begin
                c = '{rho, mom_x, mom_y, mom_z, en_xx, en_yy, en_zz, en_xy, en_xz, en_yz};
                predict_cell(c);
            end
            if (cfg_we)
            begin
                if (cfg_addr == CFG_DENSITY_FLOOR)
                    rho_min = cfg_data;
                else if (cfg_addr == CFG_PRESSURE_FLOOR)
                    p_min = cfg_data;
            end
        end
        pending = cell_q.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

endmodule

### sim/tb_conserved_to_primitive_tensor.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_conserved_to_primitive_tensor: stimulus and verdict for the converter
// Directed corner cells, then random cells under several floor settings,
// with random start gaps; the checker predicts and compares all results.
// ============================================================================
module tb_conserved_to_primitive_tensor;
    import c2pt_pkg::*;

    localparam logic CFG_DENSITY_FLOOR  = 1'b0;
    localparam logic CFG_PRESSURE_FLOOR = 1'b1;
    localparam int   DRAIN_CYCLES       = 60;    // extra wait after the queue empties
    localparam int   STALL_LIMIT        = 2000;  // cycles with no item accepted or delivered

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_we = 1'b0;
    logic cfg_addr = CFG_DENSITY_FLOOR;
    logic [DW-1:0] cfg_data = '0;
    logic signed [FW-1:0] cell_in [10];
    logic done, is_last;
    logic signed [FW-1:0] out_density, out_x, out_y, out_z;
    logic signed [FW-1:0] out_xx, out_yy, out_zz, out_xy, out_xz, out_yz;
    int fail_count, pending;
    int idle_cycles;
    bit calm;   // stretch with no idle gaps

    always #2 clk = ~clk;

    initial
        for (int i = 0; i < 10; i++)
            cell_in[i] = '0;

    conserved_to_primitive_tensor uut (
        .clk, .rst_n, .start, .busy, .cfg_we, .cfg_addr, .cfg_data,
        .rho(cell_in[0]), .mom_x(cell_in[1]), .mom_y(cell_in[2]), .mom_z(cell_in[3]),
        .en_xx(cell_in[4]), .en_yy(cell_in[5]), .en_zz(cell_in[6]),
        .en_xy(cell_in[7]), .en_xz(cell_in[8]), .en_yz(cell_in[9]),
        .done, .is_last, .out_density, .out_x, .out_y, .out_z,
        .out_xx, .out_yy, .out_zz, .out_xy, .out_xz, .out_yz
    );

    c2pt_checker chk (
        .clk, .rst_n, .start, .busy, .cfg_we, .cfg_addr, .cfg_data,
        .rho(cell_in[0]), .mom_x(cell_in[1]), .mom_y(cell_in[2]), .mom_z(cell_in[3]),
        .en_xx(cell_in[4]), .en_yy(cell_in[5]), .en_zz(cell_in[6]),
        .en_xy(cell_in[7]), .en_xz(cell_in[8]), .en_yz(cell_in[9]),
        .done, .is_last, .out_density, .out_x, .out_y, .out_z,
        .out_xx, .out_yy, .out_zz, .out_xy, .out_xz, .out_yz,
        .fail_count, .pending
    );

    // watchdog: counts cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end
    initial idle_cycles = 0;

    // one item: optional idle gap, then hold start until accepted;
    // start drops in the cycle after, while busy blocks anyway
    task automatic send_cell(input logic signed [FW-1:0] c [10]);
        while (!calm && $urandom_range(99) < 12)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        for (int i = 0; i < 10; i++)
            cell_in[i] <= c[i];
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_floor(input logic idx, input logic [DW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // block must be idle before a floor change
    task automatic drain;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random word, biased toward small magnitudes and the extremes
    function automatic logic signed [FW-1:0] rnd_word();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            4, 5:    return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_cells(input int n);
        logic signed [FW-1:0] c [10];
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 10; i++)
                c[i] = rnd_word();
            // mostly physical density so the divide path is exercised
            if ($urandom_range(3) != 0)
                c[0] = $urandom_range(32'h7FFF_FFFF, 1);
            // sometimes place diagonal energy near the floor boundary
            if ($urandom_range(3) == 0)
                c[4 + $urandom_range(2)] = $signed($urandom_range(32'h0002_0000));
            send_cell(c);
        end
    endtask

    initial
    begin
        logic signed [FW-1:0] c [10];
        logic signed [FW-1:0] corner [8][10];
        calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset floors, then corners
        corner[0] = '{32'sh0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0};           // all-zero state
        corner[1] = '{0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                      0, 0, 0, 0, 0, 0};                                      // zero rho, huge vel
        corner[2] = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        corner[3] = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        corner[4] = '{32'sh0001_0000, 0, 0, 0, 1, 2, 0, -1, 5, -5};          // pressure at floor
        corner[5] = '{32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000, 32'sh0000_8000,
                      32'sh0010_0000, -32'sh0010_0000, 32'sh0000_2000,
                      32'sh0001_0000, -32'sh0001_0000, 32'sh0000_1000};
        corner[6] = '{1, -1, 1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, 3, 4, 5, 6};
        corner[7] = '{-32'sh0001_0000, 32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000,
                      32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF,
                      32'sh8000_0000, 0};
        foreach (corner[k])
        begin
            c = corner[k];
            send_cell(c);
        end
        drain();

        // zero density floor behaves as one; zero pressure floor
        write_floor(CFG_DENSITY_FLOOR, '0);
        write_floor(CFG_PRESSURE_FLOOR, '0);
        for (int k = 0; k < 8; k++)
        begin
            c = corner[k];
            send_cell(c);
        end
        random_cells(150);
        drain();

        // maximal floors
        write_floor(CFG_DENSITY_FLOOR, {DW{1'b1}});
        write_floor(CFG_PRESSURE_FLOOR, {DW{1'b1}});
        random_cells(150);
        drain();

        // no idle gaps for a long stretch, unit-density floor
        calm = 1'b1;
        write_floor(CFG_DENSITY_FLOOR, 31'h0001_0000);
        write_floor(CFG_PRESSURE_FLOOR, 31'h0000_0100);
        random_cells(250);
        calm = 1'b0;
        drain();

        // random floors per phase
        for (int p = 0; p < 4; p++)
        begin
            write_floor(CFG_DENSITY_FLOOR, DW'($urandom));
            write_floor(CFG_PRESSURE_FLOOR, DW'($urandom_range(32'h0004_0000)));
            random_cells(100);
            drain();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
